/* sv/priority_ready_queue_scheduler_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ready queue scheduler
// Both macros sample on i_clk and stay quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_MACROS_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PRQ_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PRQ_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/prq_pkg.sv */
// ----------------------------------------------------------------------------
// prq_pkg
// Shared sizes, operation codes and types for the ready queue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package prq_pkg;

    localparam int THREADS    = 32;
    localparam int PRIORITIES = 16;
    localparam int TID_W      = $clog2(THREADS);
    localparam int PRI_W      = $clog2(PRIORITIES);

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_GET   = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    // Lowest-numbered non-empty level and whether there is one at all
    typedef struct packed {
        logic             any;
        logic [PRI_W-1:0] idx;
    } t_level;

endpackage

`default_nettype wire

/* sv/priority_ready_queue_scheduler.sv */
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Ready queue with one linked FIFO per priority level and a non-empty bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one word per kernel event:
//   operation (put, get, query), thread index and requested priority.
//   Output channel (o_out_valid / i_out_ready) returns one word per event:
//   status (1 when the event was ignored), the head of the lowest-numbered
//   non-empty level and a flag that any thread is ready.
//   An accepted event steps through states RD1, RD2 and LOAD, and no new
//   event is accepted until it has left LOAD. The states follow the chain of
//   dependent memory reads: the thread's link and priority, then the level's
//   tail, then the head of the winning level.
//   The output register holds a finished word while the next event runs;
//   if the receiver stalls, the event after that waits in its final cycle.
//   Reset (synchronous, active low) empties every level and clears all
//   queued flags; the link, priority, head and tail memories are not
//   cleared, since they are only read for queued threads and busy levels.
// ----------------------------------------------------------------------------
`default_nettype none
`include "priority_ready_queue_scheduler_macros.svh"

module priority_ready_queue_scheduler
    import prq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,

    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_operation,
    input  logic [TID_W-1:0] i_thread_id,
    input  logic [PRI_W-1:0] i_priority_req,

    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_status,
    output logic [TID_W-1:0] o_ready_thread,
    output logic             o_ready_valid
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD1  = 4'b0010,
        S_RD2  = 4'b0100,
        S_LOAD = 4'b1000
    } t_state;

    t_state r_state, n_state;

    t_op              r_op;
    logic [TID_W-1:0] r_tid;
    logic [PRI_W-1:0] r_pri;
    logic [PRI_W-1:0] r_level;

    logic [THREADS-1:0]    r_queued;
    logic [PRIORITIES-1:0] r_nonempty, n_nonempty;
    logic                  r_status;
    logic                  r_any;
    logic                  r_fwd_hit;
    logic [TID_W-1:0]      r_fwd_data;

    logic             r_out_valid;
    logic             r_o_status;
    logic [TID_W-1:0] r_o_thread;
    logic             r_o_rvalid;

    // Memories and their registered read data
    logic [TID_W-1:0] mem_link [THREADS];
    logic [PRI_W-1:0] mem_prio [THREADS];
    logic [TID_W-1:0] mem_head [PRIORITIES];
    logic [TID_W-1:0] mem_tail [PRIORITIES];
    logic [TID_W-1:0] r_link_q;
    logic [PRI_W-1:0] r_prio_q;
    logic [TID_W-1:0] r_head_q;
    logic [TID_W-1:0] r_tail_q;

    logic             in_fire;
    logic             out_free;
    logic             do_load;
    logic [PRI_W-1:0] rd1_level;
    logic             is_queued;
    logic             act_put;
    logic             act_get;
    logic             ignored;

    logic             link_we;
    logic [TID_W-1:0] link_wa;
    logic [TID_W-1:0] link_wd;
    logic             head_we;
    logic [TID_W-1:0] head_wd;
    logic             tail_we;
    logic             prio_we;

    t_level           new_level;
    logic [TID_W-1:0] head_sel;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign do_load    = (r_state == S_LOAD) && out_free;

    // A put addresses its requested level; a get uses the stored level
    assign rd1_level  = (r_op == OP_PUT) ? r_pri : r_prio_q;

    assign is_queued  = r_queued[r_tid];

    always_comb begin
        act_put = 1'b0;
        act_get = 1'b0;
        ignored = 1'b0;
        case (r_op)
            OP_PUT: begin
                act_put = !is_queued;
                ignored = is_queued;
            end
            OP_GET: begin
                act_get = is_queued;
                ignored = !is_queued;
            end
            default: begin
                ignored = 1'b0;
            end
        endcase
    end

    // Read-modify-write of the level, all in state S_RD2
    always_comb begin
        n_nonempty = r_nonempty;
        link_we    = 1'b0;
        link_wa    = r_tail_q;
        link_wd    = r_tid;
        head_we    = 1'b0;
        head_wd    = r_tid;
        tail_we    = 1'b0;
        prio_we    = 1'b0;
        if (r_state == S_RD2) begin
            if (act_put) begin
                if (r_nonempty[r_level]) begin
                    link_we = 1'b1;
                end else begin
                    head_we = 1'b1;
                end
                tail_we             = 1'b1;
                prio_we             = 1'b1;
                n_nonempty[r_level] = 1'b1;
            end else if (act_get) begin
                if (r_tail_q == r_tid) begin
                    n_nonempty[r_level] = 1'b0;
                end else begin
                    head_we = 1'b1;
                    head_wd = r_link_q;
                end
            end
        end
    end

    prq_level_enc u_level_enc (
        .i_bits  (n_nonempty),
        .o_level (new_level)
    );

    always_ff @(posedge i_clk) begin
        if (prio_we) begin
            mem_prio[r_tid] <= r_pri;
        end
        if (in_fire) begin
            r_prio_q <= mem_prio[i_thread_id];
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            mem_link[link_wa] <= link_wd;
        end
        if (in_fire) begin
            r_link_q <= mem_link[i_thread_id];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail_we) begin
            mem_tail[r_level] <= r_tid;
        end
        if (r_state == S_RD1) begin
            r_tail_q <= mem_tail[rd1_level];
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            mem_head[r_level] <= head_wd;
        end
        if (r_state == S_RD2) begin
            r_head_q <= mem_head[new_level.idx];
        end
    end

    // Payload registers along the event
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op  <= t_op'(i_operation);
            r_tid <= i_thread_id;
            r_pri <= i_priority_req;
        end
        if (r_state == S_RD1) begin
            r_level <= rd1_level;
        end
        if (r_state == S_RD2) begin
            r_status   <= ignored;
            r_any      <= new_level.any;
            // Forward a head written in the same cycle it is read
            r_fwd_hit  <= head_we && (r_level == new_level.idx);
            r_fwd_data <= head_wd;
        end
    end

    assign head_sel = r_fwd_hit ? r_fwd_data : r_head_q;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_fire) n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_LOAD;
            S_LOAD:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_queued   <= '0;
            r_nonempty <= '0;
        end else begin
            r_state    <= n_state;
            r_nonempty <= n_nonempty;
            if (r_state == S_RD2) begin
                if (act_put) begin
                    r_queued[r_tid] <= 1'b1;
                end else if (act_get) begin
                    r_queued[r_tid] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_o_status <= r_status;
            r_o_thread <= r_any ? head_sel : '0;
            r_o_rvalid <= r_any;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_ready_thread = r_o_thread;
    assign o_ready_valid  = r_o_rvalid;

    `PRQ_ASSERT_NXT(a_accept_blocks, in_fire, !o_in_ready, "input taken again while busy")
    `PRQ_ASSERT_NXT(a_put_marks, (r_state == S_RD2) && act_put, r_queued[r_tid], "put not marked")
    `PRQ_ASSERT_NXT(a_load_valid, do_load, o_ready_valid == (|r_nonempty), "ready flag wrong")
    `PRQ_ASSERT_NOW(a_idle_thread, o_out_valid && !o_ready_valid, o_ready_thread == '0, "idle thread")

endmodule

`default_nettype wire

/* sv/prq_level_enc.sv */
// ----------------------------------------------------------------------------
// prq_level_enc
// Priority encoder over the non-empty bitmap: picks the lowest set level.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_level_enc
    import prq_pkg::*;
(
    input  logic [PRIORITIES-1:0] i_bits,
    output t_level                o_level
);

    // Scan from the top so the lowest set bit wins
    always_comb begin
        o_level = '0;
        for (int n = PRIORITIES - 1; n >= 0; n--) begin
            if (i_bits[n]) begin
                o_level.any = 1'b1;
                o_level.idx = PRI_W'(n);
            end
        end
    end

endmodule

`default_nettype wire

/* sim/priority_ready_queue_scheduler_checker.sv */
// ----------------------------------------------------------------------------
// Ready queue scheduler checker
// Watches both channels of the scheduler. Keeps its own copy of the per-level
// thread lists and bitmap, works out the word each accepted event should
// return, and compares every returned word field by field against the oldest
// outstanding one.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler_checker
    import prq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,

    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [1:0]       i_operation,
    input  logic [TID_W-1:0] i_thread_id,
    input  logic [PRI_W-1:0] i_priority_req,

    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic             i_status,
    input  logic [TID_W-1:0] i_ready_thread,
    input  logic             i_ready_valid,

    output int               o_replies_due,
    output int               o_mismatches
);

    typedef struct packed {
        logic             status;
        logic [TID_W-1:0] thread;
        logic             valid;
    } t_reply;

    t_reply                replies_due[$];

    logic [TID_W-1:0]      successor  [THREADS];
    bit                    queued     [THREADS];
    logic [PRI_W-1:0]      level_of   [THREADS];
    logic [TID_W-1:0]      level_head [PRIORITIES];
    logic [TID_W-1:0]      level_tail [PRIORITIES];
    logic [PRIORITIES-1:0] busy_levels;

    int mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    // Apply one kernel event to the shadow lists and return the word it yields
    task automatic run_kernel_event(
        input  logic [1:0]       op,
        input  logic [TID_W-1:0] tid,
        input  logic [PRI_W-1:0] pri,
        output t_reply           reply
    );
        logic [PRI_W-1:0] lvl;
        reply = '0;
        if (op == OP_PUT) begin
            if (queued[tid]) begin
                reply.status = 1'b1;
            end else begin
                if (busy_levels[pri])
                    successor[level_tail[pri]] = tid;
                else
                    level_head[pri] = tid;
                level_tail[pri]  = tid;
                busy_levels[pri] = 1'b1;
                level_of[tid]    = pri;
                queued[tid]      = 1'b1;
            end
        end else if (op == OP_GET) begin
            if (!queued[tid]) begin
                reply.status = 1'b1;
            end else begin
                lvl = level_of[tid];
                // the kernel only ever unlinks the head, whatever thread is named
                if (level_tail[lvl] == tid)
                    busy_levels[lvl] = 1'b0;
                else
                    level_head[lvl] = successor[tid];
                queued[tid] = 1'b0;
            end
        end
        // walk down so the lowest-numbered busy level is written last
        for (int n = PRIORITIES - 1; n >= 0; n--) begin
            if (busy_levels[n]) begin
                reply.thread = level_head[n];
                reply.valid  = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        t_reply fresh;
        if (!i_rst_n) begin
            replies_due.delete();
            busy_levels = '0;
            for (int t = 0; t < THREADS; t++) begin
                queued[t]    = 1'b0;
                successor[t] = '0;
                level_of[t]  = '0;
            end
            for (int p = 0; p < PRIORITIES; p++) begin
                level_head[p] = '0;
                level_tail[p] = '0;
            end
        end else begin
            // a word leaving now belongs to an event accepted earlier
            if (i_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    report_mismatch("unexpected word, ready_thread", int'(i_ready_thread), 0);
                end else begin
                    want = replies_due.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", int'(i_status), int'(want.status));
                    if (i_ready_thread !== want.thread)
                        report_mismatch("ready_thread", int'(i_ready_thread),
                                        int'(want.thread));
                    if (i_ready_valid !== want.valid)
                        report_mismatch("ready_valid", int'(i_ready_valid), int'(want.valid));
                end
            end
            if (i_in_valid && i_in_ready) begin
                run_kernel_event(i_operation, i_thread_id, i_priority_req, fresh);
                replies_due.push_back(fresh);
            end
        end
        o_replies_due = replies_due.size();
    end

endmodule

/* sim/priority_ready_queue_scheduler_test.sv */
// ----------------------------------------------------------------------------
// Ready queue scheduler testbench
// Drives directed kernel events through the corner cases of the per-level
// lists, then a long random mix of mostly well-formed puts and gets with some
// ignored, queries and spare codes mixed in; bursty input, a stalling receiver.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler_test;
    import prq_pkg::*;

    localparam logic [1:0] OP_SPARE       = 2'd3;
    localparam int         RANDOM_WORDS   = 1750;
    localparam int         HOLD_OFF_CYCLES = 150;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [1:0]       i_operation;
    logic [TID_W-1:0] i_thread_id;
    logic [PRI_W-1:0] i_priority_req;
    logic             o_out_valid;
    logic             i_out_ready;
    logic             o_status;
    logic [TID_W-1:0] o_ready_thread;
    logic             o_ready_valid;

    int replies_outstanding;
    int mismatch_total;
    bit hold_off_request = 1'b0;

    // stimulus-side bookkeeping of which threads sit on which level
    bit               on_list    [THREADS];
    logic [TID_W-1:0] level_line [PRIORITIES][$];
    int               listed = 0;

    always #4 i_clk = ~i_clk;

    priority_ready_queue_scheduler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_thread_id    (i_thread_id),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_ready_thread (o_ready_thread),
        .o_ready_valid  (o_ready_valid)
    );

    priority_ready_queue_scheduler_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_thread_id    (i_thread_id),
        .i_priority_req (i_priority_req),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_status       (o_status),
        .i_ready_thread (o_ready_thread),
        .i_ready_valid  (o_ready_valid),
        .o_replies_due  (replies_outstanding),
        .o_mismatches   (mismatch_total)
    );

    task automatic idle(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // Hold the input quiet until every outstanding word has come back
    task automatic settle();
        idle(1);
        while (replies_outstanding != 0)
            @(negedge i_clk);
    endtask

    task automatic issue(
        input logic [1:0]       op,
        input logic [TID_W-1:0] tid,
        input logic [PRI_W-1:0] pri
    );
        if (op == OP_PUT && !on_list[tid]) begin
            on_list[tid] = 1'b1;
            level_line[pri].push_back(tid);
            listed++;
        end else if (op == OP_GET && on_list[tid]) begin
            on_list[tid] = 1'b0;
            listed--;
            for (int p = 0; p < PRIORITIES; p++)
                for (int k = level_line[p].size() - 1; k >= 0; k--)
                    if (level_line[p][k] == tid)
                        level_line[p].delete(k);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_thread_id    <= tid;
        i_priority_req <= pri;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic logic [TID_W-1:0] any_thread(input bit want_listed);
        logic [TID_W-1:0] tid;
        do tid = TID_W'($urandom_range(0, THREADS - 1)); while (on_list[tid] != want_listed);
        return tid;
    endfunction

    task automatic pick_word(
        output logic [1:0]       op,
        output logic [TID_W-1:0] tid,
        output logic [PRI_W-1:0] pri
    );
        int roll;
        int put_odds;
        int lvl;
        roll     = $urandom_range(0, 99);
        tid      = TID_W'($urandom_range(0, THREADS - 1));
        pri      = PRI_W'($urandom_range(0, PRIORITIES - 1));
        put_odds = (listed < 4) ? 90 : (listed > 26) ? 15 : 55;
        if (roll < 6) begin
            op = OP_QUERY;
        end else if (roll < 9) begin
            op = OP_SPARE;
        end else if (roll < 15) begin
            // events the block must ignore
            if ($urandom_range(0, 1) == 0 && listed > 0) begin
                op  = OP_PUT;
                tid = any_thread(1'b1);
            end else if (listed < THREADS) begin
                op  = OP_GET;
                tid = any_thread(1'b0);
            end else begin
                op = OP_QUERY;
            end
        end else if (listed == 0 || (listed < THREADS && $urandom_range(0, 99) < put_odds)) begin
            op  = OP_PUT;
            tid = any_thread(1'b0);
            if ($urandom_range(0, 9) < 7)
                pri = PRI_W'($urandom_range(0, 3));
        end else begin
            op   = OP_GET;
            roll = $urandom_range(0, 99);
            if (roll < 85) begin
                lvl = -1;
                for (int p = PRIORITIES - 1; p >= 0; p--)
                    if (level_line[p].size() != 0)
                        lvl = p;
                // sometimes take the head of a random busy level instead
                if (roll >= 60)
                    do lvl = $urandom_range(0, PRIORITIES - 1);
                    while (level_line[lvl].size() == 0);
                tid = level_line[lvl][0];
            end else begin
                tid = any_thread(1'b1);
            end
        end
    endtask

    // Receiver: stalls in phases of changing style, plus one long hold-off
    initial begin
        int style;
        int span;
        i_out_ready = 1'b0;
        forever begin
            if (hold_off_request) begin
                repeat (HOLD_OFF_CYCLES) begin
                    @(negedge i_clk);
                    i_out_ready <= 1'b0;
                end
                hold_off_request = 1'b0;
            end else begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(20, 150);
                repeat (span) begin
                    @(negedge i_clk);
                    case (style)
                        0: i_out_ready <= 1'b1;
                        1: i_out_ready <= ($urandom_range(0, 1) == 1);
                        2: i_out_ready <= ($urandom_range(0, 3) == 0);
                        default: i_out_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    initial begin
        #3000000;
        $display("priority_ready_queue_scheduler_test: done, errors");
        $finish;
    end

    initial begin
        logic [1:0]       op;
        logic [TID_W-1:0] tid;
        logic [PRI_W-1:0] pri;
        int               sent;
        int               burst;
        int               gap;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_operation    = OP_QUERY;
        i_thread_id    = '0;
        i_priority_req = '0;
        for (int t = 0; t < THREADS; t++)
            on_list[t] = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty scheduler, ignored get, spare code
        issue(OP_QUERY, 0, 0);
        issue(OP_GET,   0, 0);
        issue(OP_SPARE, 31, 15);
        // extremes, repeat put keeps its first level
        issue(OP_PUT,   31, 15);
        issue(OP_PUT,   0, 0);
        issue(OP_PUT,   0, 5);
        issue(OP_PUT,   5, 0);
        issue(OP_PUT,   7, 0);
        issue(OP_PUT,   10, 15);
        issue(OP_QUERY, 31, 15);
        // get from the middle, then the tail while another thread stays flagged
        issue(OP_GET,   5, 0);
        issue(OP_GET,   7, 0);
        issue(OP_GET,   0, 0);
        issue(OP_PUT,   0, 0);
        issue(OP_GET,   0, 0);
        // drain level 15 down to nothing ready
        issue(OP_GET,   31, 0);
        issue(OP_GET,   10, 0);
        issue(OP_GET,   10, 0);
        issue(OP_PUT,   21, 9);
        issue(OP_PUT,   21, 3);
        issue(OP_PUT,   26, 9);
        issue(OP_SPARE, 21, 9);
        issue(OP_GET,   21, 0);
        issue(OP_GET,   26, 0);

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                pick_word(op, tid, pri);
                issue(op, tid, pri);
                sent++;
                if (sent == 600)
                    hold_off_request = 1'b1;
                if (sent == 1200)
                    settle();
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            idle(gap);
        end

        settle();
        repeat (16) @(negedge i_clk);
        if (mismatch_total == 0)
            $display("priority_ready_queue_scheduler_test: done, clean");
        else
            $display("priority_ready_queue_scheduler_test: done, errors");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/prq_pkg.sv
sv/prq_level_enc.sv
sv/priority_ready_queue_scheduler.sv
sim/priority_ready_queue_scheduler_checker.sv
sim/priority_ready_queue_scheduler_test.sv
